/* hw/rtl/dsc_pkg.sv */
package dsc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int DEADBAND_W = 31;

    typedef enum logic [1:0] {
        REG_MIN_TIME        = 2'd0,
        REG_MAX_TIME        = 2'd1,
        REG_VALUE_DEADBAND  = 2'd2,
        REG_SAMPLE_INTERVAL = 2'd3
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] MIN_TIME_RST        = 32'd1000;
    localparam logic [CFG_DATA_W-1:0] MAX_TIME_RST        = 32'd3600000;
    localparam logic [DEADBAND_W-1:0] VALUE_DEADBAND_RST  = 31'd65536;
    localparam logic [CFG_DATA_W-1:0] SAMPLE_INTERVAL_RST = 32'd1000;

endpackage

/* hw/rtl/deadband_sample_compressor_unit.sv */
// A beat is registered in the working stage; one closing the open segment moves
// that segment to the result stage. One sample per cycle unless out_stall backs up;
// the state loop's slot add, span subtract and compares close in the working stage.
// Reset (rst_n, async, active low): both stages empty, time and segment state
// cleared to zero, configuration registers at their default values.
module deadband_sample_compressor_unit #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int TIME_WIDTH   = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  dsc_pkg::cfg_index_t               cfg_index,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample,
    input  logic                              first_of_buffer,
    input  logic [TIME_WIDTH-1:0]             start_time,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [TIME_WIDTH-1:0]             seg_start,
    output logic [TIME_WIDTH-1:0]             seg_end,
    output logic signed [SAMPLE_WIDTH-1:0]    seg_value
);
    import dsc_pkg::*;

    localparam int CMP_W = (SAMPLE_WIDTH > DEADBAND_W) ? SAMPLE_WIDTH : DEADBAND_W;

    // configuration
    logic [CFG_DATA_W-1:0] min_time_reg;
    logic [CFG_DATA_W-1:0] max_time_reg;
    logic [DEADBAND_W-1:0] value_deadband_reg;
    logic [CFG_DATA_W-1:0] sample_interval_reg;

    // input stage
    logic                    s1_valid_reg;
    logic [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                    s1_first_reg;
    logic [TIME_WIDTH-1:0]   s1_start_time_reg;

    // segment state
    logic [TIME_WIDTH-1:0]   slot_start_reg;
    logic [TIME_WIDTH-1:0]   open_start_reg;
    logic [TIME_WIDTH-1:0]   open_end_reg;
    logic [SAMPLE_WIDTH-1:0] open_value_reg;

    // result stage
    logic                    out_valid_reg;
    logic [TIME_WIDTH-1:0]   seg_start_reg;
    logic [TIME_WIDTH-1:0]   seg_end_reg;
    logic [SAMPLE_WIDTH-1:0] seg_value_reg;

    logic                    advance;
    logic                    fire;
    logic [TIME_WIDTH-1:0]   interval_ext;
    logic [TIME_WIDTH-1:0]   eff_slot;
    logic [TIME_WIDTH-1:0]   eff_ostart;
    logic [TIME_WIDTH-1:0]   eff_oend;
    logic [SAMPLE_WIDTH-1:0] eff_oval;
    logic [TIME_WIDTH-1:0]   cur_to;
    logic [TIME_WIDTH-1:0]   span;
    logic [SAMPLE_WIDTH-1:0] key_a;
    logic [SAMPLE_WIDTH-1:0] key_b;
    logic [SAMPLE_WIDTH-1:0] val_diff;
    logic                    moved;
    logic                    close_seg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign fire     = s1_valid_reg && advance;

    assign interval_ext = TIME_WIDTH'(sample_interval_reg);

    // a buffer start overrides the running state for this sample
    always_comb
    begin
        if (s1_first_reg)
        begin
            eff_slot   = s1_start_time_reg;
            eff_ostart = s1_start_time_reg;
            eff_oend   = s1_start_time_reg + interval_ext;
            eff_oval   = s1_sample_reg;
        end
        else
        begin
            eff_slot   = slot_start_reg;
            eff_ostart = open_start_reg;
            eff_oend   = open_end_reg;
            eff_oval   = open_value_reg;
        end
    end

    assign cur_to = eff_slot + interval_ext;
    assign span   = (eff_oend >= cur_to) ? (eff_oend - cur_to) : (cur_to - eff_oend);

    // offset binary turns the signed distance into an unsigned one
    assign key_a    = eff_oval ^ {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    assign key_b    = s1_sample_reg ^ {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    assign val_diff = (key_a >= key_b) ? (key_a - key_b) : (key_b - key_a);
    assign moved    = CMP_W'(val_diff) >= CMP_W'(value_deadband_reg);

    assign close_seg = (moved && (span >= TIME_WIDTH'(min_time_reg)))
                     || (span >= TIME_WIDTH'(max_time_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg        <= MIN_TIME_RST;
            max_time_reg        <= MAX_TIME_RST;
            value_deadband_reg  <= VALUE_DEADBAND_RST;
            sample_interval_reg <= SAMPLE_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_TIME:        min_time_reg        <= cfg_data;
                REG_MAX_TIME:        max_time_reg        <= cfg_data;
                REG_VALUE_DEADBAND:  value_deadband_reg  <= cfg_data[DEADBAND_W-1:0];
                REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_start_reg <= '0;
            open_start_reg <= '0;
            open_end_reg   <= '0;
            open_value_reg <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg && close_seg;
            if (fire)
            begin
                slot_start_reg <= cur_to;
                if (close_seg)
                begin
                    open_start_reg <= eff_slot;
                    open_end_reg   <= cur_to;
                    open_value_reg <= s1_sample_reg;
                end
                else
                begin
                    open_start_reg <= eff_ostart;
                    open_end_reg   <= eff_oend;
                    open_value_reg <= eff_oval;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_sample_reg     <= sample;
            s1_first_reg      <= first_of_buffer;
            s1_start_time_reg <= start_time;
        end
        if (fire && close_seg)
        begin
            seg_start_reg <= eff_ostart;
            seg_end_reg   <= eff_slot;
            seg_value_reg <= eff_oval;
        end
    end

    assign out_valid = out_valid_reg;
    assign seg_start = seg_start_reg;
    assign seg_end   = seg_end_reg;
    assign seg_value = seg_value_reg;

    // stall only backs up from a full working stage
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty working stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost before working stage");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid_reg) |=> !out_valid)
        else $error("result beat repeated");

    a_no_emit_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !out_valid) |=> !out_valid)
        else $error("result beat without a sample");

endmodule
